/* rtl/c2p_pkg.sv */
// c2p_pkg: field widths, register indexes and shared types of the
// chunky-to-planar packer; no dependencies
package c2p_pkg;

    localparam int PIX_W      = 8;   // pixel_index width
    localparam int PLANE_W    = 3;   // plane_number width
    localparam int OFS_W      = 20;  // byte_offset width
    localparam int BYTE_W     = 8;   // plane_byte width
    localparam int PCNT_W     = 4;   // plane_count register width
    localparam int DIM_W      = 11;  // frame_width / frame_height register width
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [OFS_W-1:0]     t_offset;
    typedef logic [PLANE_W-1:0]   t_plane;

    // configuration register indexes
    localparam t_cfg_idx CFG_PLANE_COUNT  = 2'd0;
    localparam t_cfg_idx CFG_FRAME_WIDTH  = 2'd1;
    localparam t_cfg_idx CFG_FRAME_HEIGHT = 2'd2;

    // reset values of the configuration registers
    localparam logic [PCNT_W-1:0] RST_PLANE_COUNT  = 4'd8;
    localparam logic [DIM_W-1:0]  RST_FRAME_WIDTH  = 11'd640;
    localparam logic [DIM_W-1:0]  RST_FRAME_HEIGHT = 11'd480;

endpackage

/* rtl/c2p_pixel_if.sv */
// c2p_pixel_if: pixel input channel, valid/ready with one colour index
// depends on c2p_pkg
interface c2p_pixel_if;
    logic                          valid;
    logic                          ready;
    logic [c2p_pkg::PIX_W-1:0]     pixel_index;

    modport source (output valid, output pixel_index, input ready);
    modport sink   (input valid, input pixel_index, output ready);
endinterface

/* rtl/c2p_result_if.sv */
// c2p_result_if: result channel, one plane byte with its frame buffer offset
// depends on c2p_pkg
interface c2p_result_if;
    logic                          valid;
    logic                          ready;
    logic [c2p_pkg::PLANE_W-1:0]   plane_number;
    logic [c2p_pkg::OFS_W-1:0]     byte_offset;
    logic [c2p_pkg::BYTE_W-1:0]    plane_byte;
    logic                          last_of_run;

    modport source (output valid, output plane_number, output byte_offset,
                    output plane_byte, output last_of_run, input ready);
    modport sink   (input valid, input plane_number, input byte_offset,
                    input plane_byte, input last_of_run, output ready);
endinterface

/* rtl/c2p_cfg_if.sv */
// c2p_cfg_if: configuration write channel, register index and write data
// depends on c2p_pkg
interface c2p_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [c2p_pkg::CFG_IDX_W-1:0]     index;
    logic [c2p_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/c2p_front.sv */
// c2p_front: accepts pixels, shifts their bits into the plane registers,
// tracks column and row and queues one entry per finished byte group; uses c2p_pkg
module c2p_front #(
    parameter int MAX_PLANES = 8,
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int WW         = 11,
    parameter int HW         = 11,
    parameter int SW         = 8,
    parameter int EW         = 85
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    c2p_pixel_if.sink                   i_pix,
    input  logic [c2p_pkg::PCNT_W-1:0]  i_np,
    input  logic [WW-1:0]               i_w,
    input  logic [HW-1:0]               i_h,
    input  logic [SW-1:0]               i_stride,
    input  logic                        i_fifo_full,
    output logic                        o_push,
    output logic [EW-1:0]               o_entry
);

    localparam int COLW = $clog2(MAX_WIDTH);
    localparam int ROWW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int DW   = MAX_PLANES * 8;

    logic [7:0]             r_shift [MAX_PLANES];
    logic [7:0]             n_shift [MAX_PLANES];
    logic [COLW-1:0]        r_col;
    logic [ROWW-1:0]        r_row;
    logic                   accept;
    logic                   row_end;
    logic                   byte_end;
    logic [2:0]             align;
    logic [ROWW+SW-1:0]     row_prod;
    logic [c2p_pkg::OFS_W-1:0] base;
    logic                   pad;
    logic [DW-1:0]          data;

    assign i_pix.ready = !i_fifo_full;
    assign accept      = i_pix.valid && !i_fifo_full;

    always_comb begin
        row_end  = int'(r_col) >= (int'(i_w) - 1);
        byte_end = (r_col[2:0] == 3'd7) || row_end;
        align    = 3'd7 - r_col[2:0];
        row_prod = r_row * i_stride;
        base     = c2p_pkg::OFS_W'(row_prod) + c2p_pkg::OFS_W'(r_col[COLW-1:3]);
        // odd byte count in the row: one zero pad byte per plane follows
        pad      = row_end && !r_col[3];
        for (int p = 0; p < MAX_PLANES; p++) begin
            if (p < int'(i_np)) begin
                n_shift[p] = {r_shift[p][6:0], i_pix.pixel_index[p]};
            end else begin
                n_shift[p] = r_shift[p];
            end
            data[8*p +: 8] = n_shift[p] << align;
        end
    end

    assign o_push  = accept && byte_end;
    assign o_entry = {pad, base, data};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            for (int p = 0; p < MAX_PLANES; p++) begin
                r_shift[p] <= '0;
            end
        end else if (accept) begin
            for (int p = 0; p < MAX_PLANES; p++) begin
                r_shift[p] <= byte_end ? 8'd0 : n_shift[p];
            end
            if (row_end) begin
                r_col <= '0;
                if (int'(r_row) >= (int'(i_h) - 1)) begin
                    r_row <= '0;
                end else begin
                    r_row <= r_row + 1'b1;
                end
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

endmodule

/* rtl/c2p_fifo.sv */
// c2p_fifo: small register queue between front and back
// no dependencies
module c2p_fifo #(
    parameter int WIDTH = 85,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr;
    logic [PW-1:0]    r_rptr;
    logic [CW-1:0]    r_count;

    assign o_full  = (int'(r_count) == DEPTH);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (int'(r_wptr) == DEPTH - 1) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (int'(r_rptr) == DEPTH - 1) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* rtl/c2p_back.sv */
// c2p_back: walks the planes of the head queue entry and, when o_res is ready,
// emits one result per cycle via an output register; uses c2p_pkg, c2p_result_if
module c2p_back #(
    parameter int MAX_PLANES = 8,
    parameter int HW         = 11,
    parameter int SW         = 8,
    parameter int EW         = 85
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [EW-1:0]               i_head,
    input  logic                        i_empty,
    output logic                        o_pop,
    input  logic [c2p_pkg::PCNT_W-1:0]  i_np,
    input  logic [SW-1:0]               i_stride,
    input  logic [HW-1:0]               i_h,
    c2p_result_if.source                o_res
);

    localparam int DW = MAX_PLANES * 8;

    logic [SW+HW-1:0]          plane_prod;
    c2p_pkg::t_offset          r_plane_size;
    c2p_pkg::t_offset          r_plane_base;
    c2p_pkg::t_plane           r_p;
    logic                      r_phase;
    logic                      r_valid;
    c2p_pkg::t_plane           r_plane;
    c2p_pkg::t_offset          r_offset;
    logic [7:0]                r_byte;
    logic                      r_last;

    logic                      load;
    logic                      take;
    logic                      last_plane;
    logic                      is_last;
    logic                      head_pad;
    c2p_pkg::t_offset          head_base;
    logic [DW-1:0]             head_data;

    assign head_pad  = i_head[EW-1];
    assign head_base = i_head[DW +: c2p_pkg::OFS_W];
    assign head_data = i_head[DW-1:0];

    assign plane_prod = i_stride * i_h;
    assign load       = !r_valid || o_res.ready;
    assign take       = load && !i_empty;
    assign last_plane = ({1'b0, r_p} == (i_np - 1'b1));
    assign is_last    = last_plane && (r_phase || !head_pad);
    assign o_pop      = take && is_last;

    assign o_res.valid        = r_valid;
    assign o_res.plane_number = r_plane;
    assign o_res.byte_offset  = r_offset;
    assign o_res.plane_byte   = r_byte;
    assign o_res.last_of_run  = r_last;

    // plane size tracks configuration; user must change it only with the queue empty, not enforced
    always_ff @(posedge i_clk) begin
        r_plane_size <= c2p_pkg::OFS_W'(plane_prod);
        if (take) begin
            r_plane  <= r_p;
            r_offset <= r_plane_base + head_base + c2p_pkg::OFS_W'(r_phase);
            r_byte   <= r_phase ? 8'd0 : head_data[8*r_p +: 8];
            r_last   <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_p          <= '0;
            r_phase      <= 1'b0;
            r_plane_base <= '0;
        end else begin
            if (load) begin
                r_valid <= !i_empty;
            end
            if (take) begin
                if (is_last) begin
                    r_p          <= '0;
                    r_phase      <= 1'b0;
                    r_plane_base <= '0;
                end else if (last_plane) begin
                    r_p          <= '0;
                    r_phase      <= 1'b1;
                    r_plane_base <= '0;
                end else begin
                    r_p          <= r_p + 1'b1;
                    r_plane_base <= r_plane_base + r_plane_size;
                end
            end
        end
    end

endmodule

/* rtl/chunky_to_planar_packer_core.sv */
// chunky_to_planar_packer_core: top level of the chunky-to-planar packer
// depends on c2p_pkg, the channel interfaces, c2p_front, c2p_fifo, c2p_back
//
//   channel   dir   handshake     payload
//   i_pix     in    valid/ready   pixel_index
//   i_cfg     in    valid/ready   index, data (always ready)
//   o_res     out   valid/ready   plane_number, byte_offset, plane_byte, last_of_run
//
// one pixel is taken per cycle while the queue has room; the back end emits
// one result per cycle while o_res is ready, so a byte group costs one result per
// plane (twice that at an odd-byte row end), which at eight planes matches one
// pixel per cycle; results reach o_res through the queue and the back end's output
// register; reset (i_rst_n low at a clock edge) clears counters, plane bits
// and the queue and restores the register defaults; a stalled output fills the
// queue and then drops i_pix.ready
module chunky_to_planar_packer_core #(
    parameter int MAX_PLANES = 8,
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    c2p_pixel_if.sink     i_pix,
    c2p_cfg_if.sink       i_cfg,
    c2p_result_if.source  o_res
);

    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int HW     = $clog2(MAX_HEIGHT + 1);
    localparam int SW     = $clog2(((MAX_WIDTH + 15) / 16) * 2 + 1);
    localparam int EW     = MAX_PLANES * 8 + c2p_pkg::OFS_W + 1;
    localparam int QDEPTH = 4;

    // configuration registers
    logic [c2p_pkg::PCNT_W-1:0] r_cfg_planes;
    logic [c2p_pkg::DIM_W-1:0]  r_cfg_width;
    logic [c2p_pkg::DIM_W-1:0]  r_cfg_height;

    // clamped working values
    logic [c2p_pkg::PCNT_W-1:0] np;
    logic [WW-1:0]              w_eff;
    logic [HW-1:0]              h_eff;
    logic [SW-1:0]              stride;

    logic                       push;
    logic                       pop;
    logic                       full;
    logic                       empty;
    logic [EW-1:0]              entry;
    logic [EW-1:0]              head;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_planes <= c2p_pkg::RST_PLANE_COUNT;
            r_cfg_width  <= c2p_pkg::RST_FRAME_WIDTH;
            r_cfg_height <= c2p_pkg::RST_FRAME_HEIGHT;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                c2p_pkg::CFG_PLANE_COUNT:  r_cfg_planes <= i_cfg.data[c2p_pkg::PCNT_W-1:0];
                c2p_pkg::CFG_FRAME_WIDTH:  r_cfg_width  <= i_cfg.data;
                c2p_pkg::CFG_FRAME_HEIGHT: r_cfg_height <= i_cfg.data;
                default: ;  // unknown index: write ignored
            endcase
        end
    end

    // zero counts as one, anything above the maximum saturates
    always_comb begin
        if (r_cfg_planes == '0) begin
            np = c2p_pkg::PCNT_W'(1);
        end else if (int'(r_cfg_planes) > MAX_PLANES) begin
            np = c2p_pkg::PCNT_W'(MAX_PLANES);
        end else begin
            np = r_cfg_planes;
        end

        if (r_cfg_width == '0) begin
            w_eff = WW'(1);
        end else if (int'(r_cfg_width) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_cfg_width);
        end

        if (r_cfg_height == '0) begin
            h_eff = HW'(1);
        end else if (int'(r_cfg_height) > MAX_HEIGHT) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(r_cfg_height);
        end

        // row stride in bytes, rounded up to a 16-bit word
        stride = SW'(((int'(w_eff) + 15) / 16) * 2);
    end

    c2p_front #(
        .MAX_PLANES (MAX_PLANES),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .WW         (WW),
        .HW         (HW),
        .SW         (SW),
        .EW         (EW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (i_pix),
        .i_np        (np),
        .i_w         (w_eff),
        .i_h         (h_eff),
        .i_stride    (stride),
        .i_fifo_full (full),
        .o_push      (push),
        .o_entry     (entry)
    );

    // byte groups waiting for the back end
    c2p_fifo #(
        .WIDTH (EW),
        .DEPTH (QDEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (entry),
        .i_pop   (pop),
        .o_data  (head),
        .o_full  (full),
        .o_empty (empty)
    );

    c2p_back #(
        .MAX_PLANES (MAX_PLANES),
        .HW         (HW),
        .SW         (SW),
        .EW         (EW)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_empty  (empty),
        .o_pop    (pop),
        .i_np     (np),
        .i_stride (stride),
        .i_h      (h_eff),
        .o_res    (o_res)
    );

endmodule
